/* hdl/swsl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swsl_pkg
// Shared types and constants of the addressed single-wire serial link.
// ----------------------------------------------------------------------------
package swsl_pkg;

  localparam int unsigned DATA_BITS_DEF = 8;

  localparam int unsigned ADDR_W   = 8;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned BIT_IDX_W = 4;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [ADDR_W-1:0] OWN_ADDR_RST = 8'h00;
  localparam logic [TICK_W-1:0] BIT_TIME_RST = 16'd10;
  localparam logic [TICK_W-1:0] TICK_MAX     = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_OWN_ADDR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BIT_TIME = 1'd1;

  typedef enum logic [3:0] {
    MODE_IDLE        = 4'd0,
    MODE_TX_START    = 4'd1,
    MODE_TX_DATA     = 4'd2,
    MODE_TX_STOP1    = 4'd3,
    MODE_TX_ADDR     = 4'd4,
    MODE_TX_STOP2    = 4'd5,
    MODE_TX_ACKWAIT  = 4'd6,
    MODE_RX_START    = 4'd7,
    MODE_RX_DATA     = 4'd8,
    MODE_RX_STOP1    = 4'd9,
    MODE_RX_ADDR     = 4'd10,
    MODE_RX_STOP2    = 4'd11,
    MODE_RX_ACKDELAY = 4'd12,
    MODE_RX_ACKPULL  = 4'd13
  } mode_e;

  // One result item; the first member sits in the highest bits.
  typedef struct packed {
    logic              busy_res;
    logic              tx_acked;
    logic              tx_done;
    logic [ADDR_W-1:0] rx_data;
    logic              rx_valid;
    logic              drive_low;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage : swsl_pkg
`default_nettype wire

/* hdl/swsl_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swsl_core
// Link state machine: bit timer, shift register, configuration registers,
// one state step per accepted transfer.
// ----------------------------------------------------------------------------
module swsl_core import swsl_pkg::*; #(
  parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [TICK_W-1:0]    cfg_data_i,
  input  wire logic                 step_i,
  input  wire logic                 line_level_i,
  input  wire logic                 send_start_i,
  input  wire logic [ADDR_W-1:0]    send_data_i,
  input  wire logic [ADDR_W-1:0]    send_address_i,
  output result_t                   result_o
);

  logic [ADDR_W-1:0]    own_addr_q;
  logic [TICK_W-1:0]    bit_time_q;

  mode_e                mode_q, mode_d;
  logic [TICK_W-1:0]    tick_q, tick_d;
  logic [BIT_IDX_W-1:0] bit_q, bit_d;
  logic [DATA_BITS-1:0] shift_q, shift_d;
  logic [DATA_BITS-1:0] held_q, held_d;
  logic                 pull_q, pull_d;

  logic [TICK_W-1:0]    full_len;
  logic [TICK_W-1:0]    half_raw;
  logic [TICK_W-1:0]    half_len;
  logic [TICK_W-1:0]    tick_inc;
  logic [BIT_IDX_W-1:0] bit_inc;
  logic                 bit_last;
  logic                 full_hit;
  logic                 half_hit;
  logic [DATA_BITS-1:0] shift_rx;
  logic [DATA_BITS-1:0] shift_tx;
  logic                 rx_valid;
  logic                 tx_done;
  logic                 tx_acked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= OWN_ADDR_RST;
      bit_time_q <= BIT_TIME_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IDX_OWN_ADDR: own_addr_q <= cfg_data_i[ADDR_W-1:0];
        CFG_IDX_BIT_TIME: bit_time_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A bit time or half bit time of zero behaves as one tick.
  assign full_len = (bit_time_q == '0) ? TICK_W'(1) : bit_time_q;
  assign half_raw = bit_time_q >> 1;
  assign half_len = (half_raw == '0) ? TICK_W'(1) : half_raw;

  assign tick_inc = (tick_q != TICK_MAX) ? tick_q + TICK_W'(1) : tick_q;
  assign full_hit = (tick_inc >= full_len);
  assign half_hit = (tick_inc >= half_len);
  assign bit_inc  = bit_q + BIT_IDX_W'(1);
  assign bit_last = (bit_inc >= BIT_IDX_W'(DATA_BITS));
  assign shift_tx = shift_q >> 1;

  always_comb begin
    shift_rx = shift_q >> 1;
    shift_rx[DATA_BITS-1] = line_level_i;
  end

  always_comb begin
    mode_d   = mode_q;
    tick_d   = tick_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    held_d   = held_q;
    pull_d   = pull_q;
    rx_valid = 1'b0;
    tx_done  = 1'b0;
    tx_acked = 1'b0;

    if (mode_q == MODE_IDLE) begin
      // A send request wins over a low line.
      if (send_start_i) begin
        shift_d = send_data_i[DATA_BITS-1:0];
        held_d  = send_address_i[DATA_BITS-1:0];
        pull_d  = 1'b1;
        tick_d  = '0;
        mode_d  = MODE_TX_START;
      end else if (!line_level_i) begin
        tick_d = '0;
        mode_d = MODE_RX_START;
      end
    end else begin
      tick_d = tick_inc;
      case (mode_q)
        MODE_TX_START, MODE_TX_STOP1: begin
          if (full_hit) begin
            tick_d = '0;
            bit_d  = '0;
            if (mode_q == MODE_TX_STOP1) begin
              shift_d = held_q;
              pull_d  = ~held_q[0];
              mode_d  = MODE_TX_ADDR;
            end else begin
              pull_d = ~shift_q[0];
              mode_d = MODE_TX_DATA;
            end
          end
        end
        MODE_TX_DATA, MODE_TX_ADDR: begin
          if (full_hit) begin
            tick_d  = '0;
            shift_d = shift_tx;
            bit_d   = bit_inc;
            if (bit_last) begin
              pull_d = 1'b0;
              mode_d = (mode_q == MODE_TX_DATA) ? MODE_TX_STOP1 : MODE_TX_STOP2;
            end else begin
              pull_d = ~shift_tx[0];
            end
          end
        end
        MODE_TX_STOP2: begin
          if (full_hit) begin
            tick_d = '0;
            mode_d = MODE_TX_ACKWAIT;
          end
        end
        MODE_TX_ACKWAIT: begin
          if (half_hit) begin
            tick_d   = '0;
            tx_done  = 1'b1;
            tx_acked = ~line_level_i;
            mode_d   = MODE_IDLE;
          end
        end
        MODE_RX_START: begin
          if (half_hit) begin
            tick_d  = '0;
            bit_d   = '0;
            shift_d = '0;
            mode_d  = line_level_i ? MODE_IDLE : MODE_RX_DATA;
          end
        end
        MODE_RX_DATA, MODE_RX_ADDR: begin
          if (full_hit) begin
            tick_d  = '0;
            shift_d = shift_rx;
            bit_d   = bit_inc;
            if (bit_last) begin
              if (mode_q == MODE_RX_DATA) begin
                held_d  = shift_rx;
                shift_d = '0;
                mode_d  = MODE_RX_STOP1;
              end else begin
                mode_d = MODE_RX_STOP2;
              end
            end
          end
        end
        MODE_RX_STOP1: begin
          // The middle stop bit is only let pass, not checked.
          if (full_hit) begin
            tick_d = '0;
            bit_d  = '0;
            mode_d = MODE_RX_ADDR;
          end
        end
        MODE_RX_STOP2: begin
          if (full_hit) begin
            tick_d = '0;
            if (line_level_i && (ADDR_W'(shift_q) == own_addr_q)) begin
              mode_d = MODE_RX_ACKDELAY;
            end else begin
              mode_d = MODE_IDLE;
            end
          end
        end
        MODE_RX_ACKDELAY: begin
          if (half_hit) begin
            tick_d = '0;
            pull_d = 1'b1;
            mode_d = MODE_RX_ACKPULL;
          end
        end
        MODE_RX_ACKPULL: begin
          if (full_hit) begin
            tick_d   = '0;
            pull_d   = 1'b0;
            rx_valid = 1'b1;
            mode_d   = MODE_IDLE;
          end
        end
        default: begin
          tick_d = '0;
          pull_d = 1'b0;
          mode_d = MODE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      held_q  <= '0;
      pull_q  <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      held_q  <= held_d;
      pull_q  <= pull_d;
    end
  end

  always_comb begin
    result_o.drive_low = pull_d;
    result_o.rx_valid  = rx_valid;
    result_o.rx_data   = rx_valid ? ADDR_W'(held_q) : '0;
    result_o.tx_done   = tx_done;
    result_o.tx_acked  = tx_acked;
    result_o.busy_res  = (mode_d != MODE_IDLE);
  end

endmodule : swsl_core
`default_nettype wire

/* hdl/swsl_obuf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// swsl_obuf
// Two-entry output buffer: result register plus skid register, so that the
// input side keeps moving while a result waits on the output side.
// ----------------------------------------------------------------------------
module swsl_obuf import swsl_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t push_data_i,
  output logic         ready_o,
  output logic         valid_o,
  input  wire logic    pop_ready_i,
  output result_t      data_o
);

  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    pop;

  assign pop     = out_valid_q & pop_ready_i;
  assign ready_o = ~skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        // No push can happen while the skid register is full.
        if (pop) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (push_i) begin
        if (!out_valid_q || pop) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_q <= push_data_i;
      end else begin
        skid_q <= push_data_i;
      end
    end
  end

endmodule : swsl_obuf
`default_nettype wire

/* hdl/addressed_single_wire_serial_link.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// addressed_single_wire_serial_link
// Half-duplex addressed transceiver on one open-drain wire, one transfer per
// clock tick of the wire, with acknowledgement by the addressed node.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         one wire tick: line level, send request, data, address
// m_axis    out        wire drive, received data, send status, busy flag
// cfg       in         own address (index 0), bit time in ticks (index 1)
//
// Each input transfer is one step of the link and yields exactly one output
// transfer. The step is computed in the same cycle and lands in the output
// buffer, so one transfer per cycle is sustained while the output accepts;
// the state register loop is the only feedback path. The two-entry buffer
// keeps the input ready while one result waits; input stalls only when both
// entries are full. Reset clears the link to idle with the wire released.
// ----------------------------------------------------------------------------
module addressed_single_wire_serial_link import swsl_pkg::*; #(
  parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // From bit 0: line_level, send_start, send_data[7:0], send_address[7:0], pad.
  input  wire logic [23:0]          s_axis_tdata_i,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // From bit 0: drive_low, rx_valid, rx_data[7:0], tx_done, tx_acked,
  // busy_res, pad.
  output logic [15:0]               m_axis_tdata_o,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [TICK_W-1:0]    cfg_data_i
);

  logic    in_xfer;
  result_t step_res;
  result_t out_res;

  assign in_xfer = s_axis_tvalid_i & s_axis_tready_o;

  swsl_core #(
    .DATA_BITS(DATA_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .step_i        (in_xfer),
    .line_level_i  (s_axis_tdata_i[0]),
    .send_start_i  (s_axis_tdata_i[1]),
    .send_data_i   (s_axis_tdata_i[9:2]),
    .send_address_i(s_axis_tdata_i[17:10]),
    .result_o      (step_res)
  );

  swsl_obuf u_obuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_xfer),
    .push_data_i(step_res),
    .ready_o    (s_axis_tready_o),
    .valid_o    (m_axis_tvalid_o),
    .pop_ready_i(m_axis_tready_i),
    .data_o     (out_res)
  );

  assign m_axis_tdata_o = {(16 - RESULT_W)'(0), out_res};

endmodule : addressed_single_wire_serial_link
`default_nettype wire
